### src/sptab_pkg.sv
package sptab_pkg;

    localparam logic [1:0] CMD_SEARCH = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_BAD    = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 7;
    localparam int COUNT_W  = 7;
    localparam int POS_W    = 8;
    localparam int FIELD_W  = 16;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  index;
        logic [COUNT_W-1:0]  entry_count;
    } t_res;

endpackage

### src/sptab_ram.sv
module sptab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/sptab_ctrl.sv
module sptab_ctrl import sptab_pkg::*; #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_PART_BITS = 16,
    localparam int KEY_W = 2 * KEY_PART_BITS,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1),
    localparam int PW = (CW > INDEX_W) ? CW : INDEX_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [1:0]          i_cmd,
    input  logic [FIELD_W-1:0]  i_source_id,
    input  logic [FIELD_W-1:0]  i_device_id,
    input  logic [POS_W-1:0]    i_position,
    output logic                o_busy,
    output logic                o_res_valid,
    output t_res                o_res,
    input  logic                i_res_take,
    output logic                o_we,
    output logic [AW-1:0]       o_waddr,
    output logic [KEY_W-1:0]    o_wdata,
    output logic                o_re,
    output logic [AW-1:0]       o_raddr,
    input  logic [KEY_W-1:0]    i_rdata
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_DECODE = 12'b000000000010,
        S_SRCH   = 12'b000000000100,
        S_SCMP   = 12'b000000001000,
        S_ACHK   = 12'b000000010000,
        S_PCMP   = 12'b000000100000,
        S_NCMP   = 12'b000001000000,
        S_INSGO  = 12'b000010000000,
        S_ISHIFT = 12'b000100000000,
        S_IWR    = 12'b001000000000,
        S_RSHIFT = 12'b010000000000,
        S_DONE   = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic [1:0]          r_cmd, n_cmd;
    logic                r_neg, n_neg;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [PW-1:0]       r_p, n_p;
    logic [PW-1:0]       r_lo, n_lo;
    logic [PW-1:0]       r_hi, n_hi;
    logic [PW-1:0]       r_mid, n_mid;
    logic [PW-1:0]       r_wi, n_wi;
    logic [CW-1:0]       r_count, n_count;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [INDEX_W-1:0]  r_index, n_index;

    logic [PW:0]   w_sum;
    logic [PW-1:0] w_mid;
    logic [PW-1:0] w_cnt;
    logic [PW-1:0] w_pm1;
    logic [PW-1:0] w_pp1;
    logic [PW-1:0] w_cm1;
    logic [PW-1:0] w_wim1;
    logic [PW-1:0] w_wim2;
    logic [PW-1:0] w_wip1;
    logic [PW-1:0] w_wip2;
    logic [PW-1:0] w_ra;
    logic [PW-1:0] w_wa;

    assign w_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid  = w_sum[PW:1];
    assign w_cnt  = PW'(r_count);
    assign w_pm1  = r_p - PW'(1);
    assign w_pp1  = r_p + PW'(1);
    assign w_cm1  = w_cnt - PW'(1);
    assign w_wim1 = r_wi - PW'(1);
    assign w_wim2 = r_wi - PW'(2);
    assign w_wip1 = r_wi + PW'(1);
    assign w_wip2 = r_wi + PW'(2);

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_neg    = r_neg;
        n_key    = r_key;
        n_p      = r_p;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_wi     = r_wi;
        n_count  = r_count;
        n_status = r_status;
        n_index  = r_index;
        o_re     = 1'b0;
        o_we     = 1'b0;
        w_ra     = '0;
        w_wa     = '0;
        o_wdata  = i_rdata;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd   = i_cmd;
                    n_neg   = i_position[POS_W-1];
                    n_key   = {KEY_PART_BITS'(i_source_id), KEY_PART_BITS'(i_device_id)};
                    n_p     = PW'(i_position[POS_W-2:0]);
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_lo = '0;
                n_hi = w_cnt;
                case (r_cmd)
                    CMD_SEARCH: begin
                        n_state = S_SRCH;
                    end
                    CMD_ADD: begin
                        if (r_neg) begin
                            n_state = S_SRCH;
                        end else if (r_p > w_cnt) begin
                            n_status = ST_BAD;
                            n_index  = r_p[INDEX_W-1:0];
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_ACHK;
                        end
                    end
                    CMD_REMOVE: begin
                        if (r_neg) begin
                            n_status = ST_BAD;
                            n_index  = '0;
                            n_state  = S_DONE;
                        end else if (r_p >= w_cnt) begin
                            n_status = ST_BAD;
                            n_index  = r_p[INDEX_W-1:0];
                            n_state  = S_DONE;
                        end else if (w_pp1 < w_cnt) begin
                            o_re    = 1'b1;
                            w_ra    = w_pp1;
                            n_wi    = r_p;
                            n_state = S_RSHIFT;
                        end else begin
                            n_count  = r_count - CW'(1);
                            n_status = ST_OK;
                            n_index  = r_p[INDEX_W-1:0];
                            n_state  = S_DONE;
                        end
                    end
                    default: begin
                        n_status = ST_BAD;
                        n_index  = '0;
                        n_state  = S_DONE;
                    end
                endcase
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    o_re    = 1'b1;
                    w_ra    = w_mid;
                    n_mid   = w_mid;
                    n_state = S_SCMP;
                end else if (r_cmd == CMD_ADD) begin
                    n_p     = r_lo;
                    n_state = S_INSGO;
                end else begin
                    n_status = ST_ABSENT;
                    n_index  = r_lo[INDEX_W-1:0];
                    n_state  = S_DONE;
                end
            end
            S_SCMP: begin
                if (r_key < i_rdata) begin
                    n_hi    = r_mid;
                    n_state = S_SRCH;
                end else if (r_key > i_rdata) begin
                    n_lo    = r_mid + PW'(1);
                    n_state = S_SRCH;
                end else begin
                    n_status = (r_cmd == CMD_ADD) ? ST_ABSENT : ST_OK;
                    n_index  = r_mid[INDEX_W-1:0];
                    n_state  = S_DONE;
                end
            end
            S_ACHK: begin
                if (r_p != '0) begin
                    o_re    = 1'b1;
                    w_ra    = w_pm1;
                    n_state = S_PCMP;
                end else if (r_p < w_cnt) begin
                    o_re    = 1'b1;
                    w_ra    = r_p;
                    n_state = S_NCMP;
                end else begin
                    n_state = S_INSGO;
                end
            end
            S_PCMP: begin
                n_index = r_p[INDEX_W-1:0];
                if (r_key == i_rdata) begin
                    n_status = ST_ABSENT;
                    n_state  = S_DONE;
                end else if (r_key < i_rdata) begin
                    n_status = ST_BAD;
                    n_state  = S_DONE;
                end else if (r_p < w_cnt) begin
                    o_re    = 1'b1;
                    w_ra    = r_p;
                    n_state = S_NCMP;
                end else begin
                    n_state = S_INSGO;
                end
            end
            S_NCMP: begin
                n_index = r_p[INDEX_W-1:0];
                if (r_key == i_rdata) begin
                    n_status = ST_ABSENT;
                    n_state  = S_DONE;
                end else if (r_key > i_rdata) begin
                    n_status = ST_BAD;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_INSGO;
                end
            end
            S_INSGO: begin
                if (r_count >= CW'(TABLE_DEPTH)) begin
                    n_status = ST_FULL;
                    n_index  = r_p[INDEX_W-1:0];
                    n_state  = S_DONE;
                end else if (w_cnt > r_p) begin
                    o_re    = 1'b1;
                    w_ra    = w_cm1;
                    n_wi    = w_cnt;
                    n_state = S_ISHIFT;
                end else begin
                    n_state = S_IWR;
                end
            end
            S_ISHIFT: begin
                // read-ahead of the entry below while the previous one lands
                o_we = 1'b1;
                w_wa = r_wi;
                if (w_wim1 > r_p) begin
                    o_re = 1'b1;
                    w_ra = w_wim2;
                    n_wi = w_wim1;
                end else begin
                    n_state = S_IWR;
                end
            end
            S_IWR: begin
                o_we     = 1'b1;
                w_wa     = r_p;
                o_wdata  = r_key;
                n_count  = r_count + CW'(1);
                n_status = ST_OK;
                n_index  = r_p[INDEX_W-1:0];
                n_state  = S_DONE;
            end
            S_RSHIFT: begin
                o_we = 1'b1;
                w_wa = r_wi;
                if (w_wip2 < w_cnt) begin
                    o_re = 1'b1;
                    w_ra = w_wip2;
                    n_wi = w_wip1;
                end else begin
                    n_count  = r_count - CW'(1);
                    n_status = ST_OK;
                    n_index  = r_p[INDEX_W-1:0];
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_neg    <= n_neg;
        r_key    <= n_key;
        r_p      <= n_p;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_wi     <= n_wi;
        r_status <= n_status;
        r_index  <= n_index;
    end

    assign o_raddr = w_ra[AW-1:0];
    assign o_waddr = w_wa[AW-1:0];
    assign o_busy  = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res.status      = r_status;
    assign o_res.index       = r_index;
    assign o_res.entry_count = w_cnt[COUNT_W-1:0];

endmodule

### src/sorted_pair_key_table.sv
// Sorted table of (source_id, device_id) keys, ascending, source_id first.
// Input channel: i_valid / o_stall with i_cmd, i_source_id, i_device_id,
// i_position. Output channel: o_valid / i_stall with o_status, o_index,
// o_entry_count. Every input transaction yields exactly one output
// transaction, in order.
// One command is in flight at a time; o_stall is high from acceptance until
// the result moves into the output register. Each command is a sequence of
// steps on the key RAM, which has a separate read and write port; n = entries
// before the command, s = binary search steps (at most ceil(log2(n+1))):
//   search: binary search of s steps, then the result
//   add:    search or neighbour check, then entries moved up, one per cycle
//   remove: entries above the position moved down, one per cycle
// A new command is taken while a finished result waits in the output
// register; a stalled result holds, and the next result waits in the
// sequencer until the register frees up.
// Reset (synchronous, active low) empties the table and drops any pending
// result; the key RAM itself is not cleared, since only entries below the
// entry count are ever read.
module sorted_pair_key_table import sptab_pkg::*; #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_PART_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_cmd,
    input  logic [FIELD_W-1:0]  i_source_id,
    input  logic [FIELD_W-1:0]  i_device_id,
    input  logic [POS_W-1:0]    i_position,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [INDEX_W-1:0]  o_index,
    output logic [COUNT_W-1:0]  o_entry_count
);

    localparam int KEY_W = 2 * KEY_PART_BITS;
    localparam int AW = $clog2(TABLE_DEPTH);

    logic             w_busy;
    logic             w_res_valid;
    t_res             w_res;
    logic             w_take;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [KEY_W-1:0] w_wdata;
    logic             w_re;
    logic [AW-1:0]    w_raddr;
    logic [KEY_W-1:0] w_rdata;

    logic r_out_valid;
    t_res r_out;

    sptab_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .KEY_PART_BITS(KEY_PART_BITS)
    ) u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_valid && !w_busy),
        .i_cmd(i_cmd),
        .i_source_id(i_source_id),
        .i_device_id(i_device_id),
        .i_position(i_position),
        .o_busy(w_busy),
        .o_res_valid(w_res_valid),
        .o_res(w_res),
        .i_res_take(w_take),
        .o_we(w_we),
        .o_waddr(w_waddr),
        .o_wdata(w_wdata),
        .o_re(w_re),
        .o_raddr(w_raddr),
        .i_rdata(w_rdata)
    );

    sptab_ram #(
        .WIDTH(KEY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_keys (
        .i_clk(i_clk),
        .i_we(w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re(w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_take = w_res_valid && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= w_res;
        end
    end

    assign o_stall       = w_busy;
    assign o_valid       = r_out_valid;
    assign o_status      = r_out.status;
    assign o_index       = r_out.index;
    assign o_entry_count = r_out.entry_count;

endmodule

### src/sptab_chk.sv
module sptab_chk import sptab_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic [STATUS_W-1:0] o_status,
    input logic [INDEX_W-1:0]  o_index,
    input logic [COUNT_W-1:0]  o_entry_count
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // one command in flight: stall rises right after acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second transaction accepted while busy");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status) && $stable(o_index)
                                  && $stable(o_entry_count)))
        else $error("stalled result changed");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (XW'(o_entry_count) <= XW'(TABLE_DEPTH)))
        else $error("entry count above table depth");

endmodule

bind sorted_pair_key_table sptab_chk #(.TABLE_DEPTH(TABLE_DEPTH)) u_sptab_chk (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(i_valid),
    .o_stall(o_stall),
    .o_valid(o_valid),
    .i_stall(i_stall),
    .o_status(o_status),
    .o_index(o_index),
    .o_entry_count(o_entry_count)
);

### sim/key_table_checker.sv
module key_table_checker import sptab_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  logic                i_req_stall,
    input  logic [1:0]          i_cmd,
    input  logic [FIELD_W-1:0]  i_source_id,
    input  logic [FIELD_W-1:0]  i_device_id,
    input  logic [POS_W-1:0]    i_position,
    input  logic                i_rsp_valid,
    input  logic                i_rsp_stall,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [INDEX_W-1:0]  i_index,
    input  logic [COUNT_W-1:0]  i_entry_count,
    output int                  o_errors,
    output int                  o_pending
);

    logic [2*FIELD_W-1:0] sorted_keys [DEPTH];
    int unsigned          key_count;
    t_res                 pending_results [$];
    t_res                 want;
    t_res                 got;
    int                   mismatch_count;

    // binary search; returns 1 on a hit, where = index or insertion point
    function automatic logic locate_key(input logic [2*FIELD_W-1:0] key,
                                        output int unsigned where);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = key_count;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (key < sorted_keys[mid]) begin
                hi = mid;
            end else if (key > sorted_keys[mid]) begin
                lo = mid + 1;
            end else begin
                where = mid;
                return 1'b1;
            end
        end
        where = lo;
        return 1'b0;
    endfunction

    task automatic apply_table_command(input logic [1:0] cmd,
                                       input logic [2*FIELD_W-1:0] key,
                                       input logic [POS_W-1:0] pos,
                                       output t_res res);
        int unsigned    p;
        int unsigned    i;
        logic           accepted;
        logic [1:0]     st;
        p = 0;
        st = ST_BAD;
        accepted = 1'b1;
        case (cmd)
            CMD_SEARCH: begin
                st = locate_key(key, p) ? ST_OK : ST_ABSENT;
            end
            CMD_ADD: begin
                if (pos[POS_W-1]) begin
                    if (locate_key(key, p)) begin
                        st = ST_ABSENT;
                        accepted = 1'b0;
                    end
                end else begin
                    p = pos;
                    if (p > key_count) begin
                        st = ST_BAD;
                        accepted = 1'b0;
                    end else if (p > 0 && key == sorted_keys[p-1]) begin
                        st = ST_ABSENT;
                        accepted = 1'b0;
                    end else if (p > 0 && key < sorted_keys[p-1]) begin
                        st = ST_BAD;
                        accepted = 1'b0;
                    end else if (p < key_count && key == sorted_keys[p]) begin
                        st = ST_ABSENT;
                        accepted = 1'b0;
                    end else if (p < key_count && key > sorted_keys[p]) begin
                        st = ST_BAD;
                        accepted = 1'b0;
                    end
                end
                if (accepted) begin
                    if (key_count >= DEPTH) begin
                        st = ST_FULL;
                    end else begin
                        for (i = key_count; i > p; i--) begin
                            sorted_keys[i] = sorted_keys[i-1];
                        end
                        sorted_keys[p] = key;
                        key_count++;
                        st = ST_OK;
                    end
                end
            end
            CMD_REMOVE: begin
                if (!pos[POS_W-1]) begin
                    p = pos;
                    if (p < key_count) begin
                        for (i = p; i + 1 < key_count; i++) begin
                            sorted_keys[i] = sorted_keys[i+1];
                        end
                        key_count--;
                        st = ST_OK;
                    end
                end
            end
            default: begin
                st = ST_BAD;
            end
        endcase
        res.status = st;
        res.index = p[INDEX_W-1:0];
        res.entry_count = key_count[COUNT_W-1:0];
    endtask

    initial begin
        key_count = 0;
        mismatch_count = 0;
        o_errors = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_count = 0;
            pending_results.delete();
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                got.status = i_status;
                got.index = i_index;
                got.entry_count = i_entry_count;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result status=%0d index=%0d count=%0d",
                             $time, got.status, got.index, got.entry_count);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch: expected status=%0d index=%0d count=%0d, got status=%0d index=%0d count=%0d",
                                 $time, want.status, want.index, want.entry_count,
                                 got.status, got.index, got.entry_count);
                        mismatch_count++;
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                apply_table_command(i_cmd, {i_source_id, i_device_id}, i_position, want);
                pending_results.push_back(want);
            end
        end
        o_errors <= mismatch_count;
        o_pending <= pending_results.size();
    end

endmodule

### sim/testbench.sv
module testbench;
    import sptab_pkg::*;

    localparam int DEPTH        = 64;
    localparam int ITEM_TARGET  = 1450;
    localparam int HOLD_CYCLES  = 400;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [1:0]          i_cmd;
    logic [FIELD_W-1:0]  i_source_id;
    logic [FIELD_W-1:0]  i_device_id;
    logic [POS_W-1:0]    i_position;
    logic                o_valid;
    logic                i_stall;
    logic [STATUS_W-1:0] o_status;
    logic [INDEX_W-1:0]  o_index;
    logic [COUNT_W-1:0]  o_entry_count;

    int   fail_count;
    int   table_pending;
    int   items_sent;
    int   results_seen;
    int   last_index;
    int   last_count;
    logic hold_req;
    logic gaps_on;

    sorted_pair_key_table #(
        .TABLE_DEPTH(DEPTH),
        .KEY_PART_BITS(FIELD_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_cmd(i_cmd),
        .i_source_id(i_source_id),
        .i_device_id(i_device_id),
        .i_position(i_position),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_status(o_status),
        .o_index(o_index),
        .o_entry_count(o_entry_count)
    );

    key_table_checker #(.DEPTH(DEPTH)) table_check (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req_valid(i_valid),
        .i_req_stall(o_stall),
        .i_cmd(i_cmd),
        .i_source_id(i_source_id),
        .i_device_id(i_device_id),
        .i_position(i_position),
        .i_rsp_valid(o_valid),
        .i_rsp_stall(i_stall),
        .i_status(o_status),
        .i_index(o_index),
        .i_entry_count(o_entry_count),
        .o_errors(fail_count),
        .o_pending(table_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("testbench: done, errors");
        $finish;
    end

    // mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // small pool so hits and duplicates are common, with extremes mixed in
    function automatic logic [FIELD_W-1:0] pick_key_part();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return FIELD_W'($urandom_range(0, 15));
        end else if (r < 88) begin
            return FIELD_W'($urandom_range(16'hFFF0, 16'hFFFF));
        end else if (r < 94) begin
            return (r < 91) ? '0 : '1;
        end
        return FIELD_W'($urandom);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen <= results_seen + 1;
            last_index <= o_index;
            last_count <= o_entry_count;
        end
    end

    // receiver side
    initial begin
        int stall_left;
        int calm_left;
        int r;
        logic hold_done;
        stall_left = 0;
        calm_left = 0;
        hold_done = 1'b0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (calm_left > 0) begin
                calm_left--;
                i_stall <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 2) begin
                    calm_left = $urandom_range(50, 300);
                end
                if (r >= 70) begin
                    stall_left = pick_gap();
                end
                i_stall <= (r >= 70);
            end
        end
    end

    task automatic issue_command(input logic [1:0] cmd, input logic [FIELD_W-1:0] src,
                                 input logic [FIELD_W-1:0] dev, input logic [POS_W-1:0] pos);
        int n;
        n = gaps_on ? pick_gap() : 0;
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_source_id <= src;
        i_device_id <= dev;
        i_position <= pos;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic wait_for_results();
        while (results_seen < items_sent) @(posedge i_clk);
    endtask

    task automatic issue_noise();
        issue_command(2'($urandom_range(0, 3)), FIELD_W'($urandom), FIELD_W'($urandom),
                      POS_W'($urandom));
    endtask

    // search, then add at the returned insertion point (sometimes off by one or past the entry count)
    task automatic add_at_search_point();
        logic [FIELD_W-1:0] src;
        logic [FIELD_W-1:0] dev;
        int r;
        int p;
        src = pick_key_part();
        dev = pick_key_part();
        issue_command(CMD_SEARCH, src, dev, '1);
        wait_for_results();
        r = $urandom_range(0, 99);
        p = last_index;
        if (r >= 90) begin
            p = last_count + 1;
        end else if (r >= 85) begin
            p = last_index + 1;
        end else if (r >= 80 && last_index > 0) begin
            p = last_index - 1;
        end
        issue_command(CMD_ADD, src, dev, POS_W'(p));
    endtask

    task automatic fill_table();
        int rounds;
        int r;
        rounds = 0;
        do begin
            repeat (12) begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    issue_command(CMD_ADD, pick_key_part(), pick_key_part(), '1);
                end else if (r < 70) begin
                    issue_command(CMD_ADD, pick_key_part(), pick_key_part(),
                                  {1'b1, 7'($urandom)});
                end else if (r < 85) begin
                    issue_command(CMD_SEARCH, pick_key_part(), pick_key_part(),
                                  POS_W'($urandom));
                end else if (r < 93) begin
                    add_at_search_point();
                end else begin
                    issue_noise();
                end
            end
            wait_for_results();
            rounds++;
        end while (last_count < DEPTH && rounds < 30);
    endtask

    task automatic probe_full_table();
        int r;
        repeat (12) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                issue_command(CMD_ADD, FIELD_W'($urandom), FIELD_W'($urandom), '1);
            end else if (r < 75) begin
                add_at_search_point();
            end else begin
                issue_command(CMD_SEARCH, pick_key_part(), pick_key_part(), '0);
            end
        end
        wait_for_results();
    endtask

    task automatic drain_table();
        int rounds;
        int r;
        rounds = 0;
        do begin
            repeat (12) begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    issue_command(CMD_REMOVE, FIELD_W'($urandom), FIELD_W'($urandom),
                                  POS_W'($urandom_range(0, (last_count > 0) ? last_count - 1 : 0)));
                end else if (r < 88) begin
                    issue_command(CMD_SEARCH, pick_key_part(), pick_key_part(), '0);
                end else begin
                    issue_command(CMD_REMOVE, '0, '0, POS_W'($urandom));
                end
            end
            wait_for_results();
            rounds++;
        end while (last_count > 0 && rounds < 30);
    endtask

    task automatic mix_commands();
        int r;
        logic [1:0] cmd;
        logic [POS_W-1:0] pos;
        repeat (120) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                cmd = CMD_SEARCH;
            end else if (r < 70) begin
                cmd = CMD_ADD;
            end else if (r < 95) begin
                cmd = CMD_REMOVE;
            end else begin
                cmd = 2'd3;
            end
            r = $urandom_range(0, 99);
            if (r < 40) begin
                pos = '1;
            end else if (r < 80) begin
                pos = POS_W'($urandom_range(0, last_count + 1));
            end else begin
                pos = POS_W'($urandom);
            end
            issue_command(cmd, pick_key_part(), pick_key_part(), pos);
        end
    endtask

    initial begin
        int n;
        items_sent = 0;
        results_seen <= 0;
        last_index <= 0;
        last_count <= 0;
        hold_req <= 1'b0;
        gaps_on = 1'b1;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_cmd <= CMD_SEARCH;
        i_source_id <= '0;
        i_device_id <= '0;
        i_position <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        issue_command(CMD_SEARCH, 16'h0000, 16'h0000, 8'h00);   // empty table
        issue_command(CMD_REMOVE, 16'h0000, 16'h0000, 8'h00);   // remove from empty
        issue_command(CMD_REMOVE, 16'h0000, 16'h0000, 8'hFF);   // negative remove
        issue_command(2'd3, 16'hFFFF, 16'hFFFF, 8'h55);         // unused command
        issue_command(CMD_ADD, 16'h0010, 16'h0010, 8'h01);      // past entry count
        issue_command(CMD_ADD, 16'h0010, 16'h0010, 8'h00);
        issue_command(CMD_ADD, 16'hFFFF, 16'hFFFF, 8'hFF);
        issue_command(CMD_ADD, 16'h0000, 16'h0000, 8'h80);
        issue_command(CMD_ADD, 16'h0010, 16'h0010, 8'hFF);      // duplicate by search
        issue_command(CMD_SEARCH, 16'h0010, 16'h0010, 8'hAA);   // hit
        issue_command(CMD_SEARCH, 16'h0010, 16'h0011, 8'h00);   // miss
        issue_command(CMD_ADD, 16'h0000, 16'h0000, 8'h01);      // equals previous
        issue_command(CMD_ADD, 16'h0010, 16'h0010, 8'h01);      // equals next
        issue_command(CMD_ADD, 16'h0008, 16'hFFFF, 8'h02);      // below previous
        issue_command(CMD_ADD, 16'h0020, 16'h0000, 8'h01);      // above next
        issue_command(CMD_ADD, 16'h8000, 16'h8000, 8'h02);
        issue_command(CMD_ADD, 16'hFFFF, 16'hFFFF, 8'h04);
        issue_command(CMD_ADD, 16'h1234, 16'h5678, 8'd64);
        issue_command(CMD_ADD, 16'h1234, 16'h5678, 8'h7F);
        issue_command(CMD_REMOVE, 16'hFFFF, 16'hFFFF, 8'h7F);
        issue_command(CMD_SEARCH, 16'h8000, 16'h8000, 8'h00);
        issue_command(CMD_REMOVE, 16'h0000, 16'h0000, 8'h03);   // last entry
        issue_command(CMD_REMOVE, 16'h0000, 16'h0000, 8'h00);   // first entry
        issue_command(CMD_SEARCH, 16'hFFFF, 16'hFFFF, 8'h00);
        issue_command(CMD_REMOVE, 16'h0000, 16'h0000, 8'h01);
        wait_for_results();

        // random: fill to full, poke the full table, drain, then free mix
        while (items_sent < ITEM_TARGET) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            fill_table();
            gaps_on = ($urandom_range(0, 3) != 0);
            probe_full_table();
            gaps_on = ($urandom_range(0, 3) != 0);
            drain_table();
            gaps_on = ($urandom_range(0, 3) != 0);
            hold_req <= 1'b1;
            mix_commands();
            wait_for_results();
        end
        i_valid <= 1'b0;

        n = 0;
        while (results_seen < items_sent && n < 20000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && table_pending == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
